[rtl/assert_macros.svh]
// assertion macros used by the allocator unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property that must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

[rtl/gia_pkg.sv]
// package of the grouped inode bitmap allocator: field widths, codes, defaults
package gia_pkg;

  // payload field widths
  localparam int OP_W     = 2;
  localparam int INODE_W  = 12;
  localparam int GROUP_W  = 5;
  localparam int STATUS_W = 2;

  // default geometry
  localparam int DEF_NUM_GROUPS       = 8;
  localparam int DEF_INODES_PER_GROUP = 256;

  // operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_MARK  = 2'd2;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STS_NO_FREE   = 2'd1;
  localparam logic [STATUS_W-1:0] STS_BAD_INODE = 2'd2;
  localparam logic [STATUS_W-1:0] STS_BAD_GROUP = 2'd3;

  // bitmap byte with every inode in use
  localparam logic [7:0] FULL_BYTE = 8'hff;

endpackage

[rtl/gia_req_if.sv]
// request channel: operation, inode number and preferred group
interface gia_req_if import gia_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic [INODE_W-1:0]        inode_number;
  logic signed [GROUP_W-1:0] preferred_group;

  modport source (output valid, operation, inode_number, preferred_group, input ready);
  modport sink   (input valid, operation, inode_number, preferred_group, output ready);
endinterface

[rtl/gia_rsp_if.sv]
// response channel: status, allocated inode, bit state and total free count
interface gia_rsp_if import gia_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [INODE_W-1:0]  allocated_inode;
  logic                in_use;
  logic [INODE_W-1:0]  total_free_count;

  modport source (output valid, status, allocated_inode, in_use, total_free_count,
                  input ready);
  modport sink   (input valid, status, allocated_inode, in_use, total_free_count,
                  output ready);
endinterface

[rtl/grouped_inode_bitmap_allocator_unit.sv]
// Free, mark used and query pass through the decode, address, read-data and done states;
// errors go from decode straight to done. Allocate stays in read-data for each full bitmap
// byte skipped in the chosen group. A new item is accepted only in idle, after the last result
// has been loaded, and the allocate scan is bounded by the byte-per-cycle read of the bitmap ram.
// Reset: a clearing pass over all NUM_GROUPS * BYTES_PER_GROUP bytes (256 by default) zeroes
// the bitmap ram with ready low; counts load at once to full.
`include "assert_macros.svh"
module grouped_inode_bitmap_allocator_unit import gia_pkg::*; #(
  parameter int NUM_GROUPS       = DEF_NUM_GROUPS,
  parameter int INODES_PER_GROUP = DEF_INODES_PER_GROUP
) (
  input logic       clk,
  input logic       rst,
  gia_req_if.sink   req,
  gia_rsp_if.source rsp
);

  localparam int BYTES_PER_GROUP = (INODES_PER_GROUP + 7) / 8;
  localparam int DEPTH           = NUM_GROUPS * BYTES_PER_GROUP;
  localparam int TOTAL_INODES    = NUM_GROUPS * INODES_PER_GROUP;
  localparam int ADDR_W          = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int GRP_W           = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int BYTE_W          = (BYTES_PER_GROUP > 1) ? $clog2(BYTES_PER_GROUP) : 1;
  localparam int CNT_W           = $clog2(INODES_PER_GROUP + 1);
  localparam int TOT_W           = $clog2(TOTAL_INODES + 1);
  localparam int CALC_W          = (TOT_W > INODE_W) ? TOT_W : INODE_W;
  localparam int LAST_BITS       = INODES_PER_GROUP % 8;
  localparam logic [7:0] PAD_MASK =
    (LAST_BITS == 0) ? 8'h00 : 8'(~((8'h01 << LAST_BITS) - 8'h01));

  // state codes
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_ADDR   = 3'd3;
  localparam logic [2:0] S_RDATA  = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]          state;
  logic [2:0]          state_next;
  logic [ADDR_W-1:0]   clr_addr;
  logic [CNT_W-1:0]    counts [NUM_GROUPS];
  logic [TOT_W-1:0]    total;

  // latched request and working registers
  logic [OP_W-1:0]     op_r;
  logic [INODE_W-1:0]  inum_r;
  logic [GROUP_W-1:0]  grp_r;
  logic [GRP_W-1:0]    g_r;
  logic [CALC_W-1:0]   off_r;
  logic [BYTE_W-1:0]   byte_r;
  logic [2:0]          bit_r;
  logic [ADDR_W-1:0]   rd_addr;
  logic [ADDR_W-1:0]   rd_addr_next;
  logic [STATUS_W-1:0] res_status;
  logic                res_in_use;

  // response registers
  logic                rsp_valid;
  logic [STATUS_W-1:0] rsp_status;
  logic [INODE_W-1:0]  rsp_inode;
  logic                rsp_in_use;
  logic [INODE_W-1:0]  rsp_total;

  // ram port signals
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [7:0]          ram_wdata;
  logic [7:0]          rdata;

  // decode and scan helpers
  logic                bad_grp;
  logic [GRP_W-1:0]    pick_g;
  logic                pick_ok;
  logic [GRP_W-1:0]    pref_g;
  logic [GRP_W-1:0]    alloc_g;
  logic                alloc_ok;
  logic [CALC_W-1:0]   inum_ext;
  logic [CALC_W-1:0]   off;
  logic                bad_inode;
  logic [GRP_W-1:0]    inode_g;
  logic [CALC_W-1:0]   loc_off;
  logic [ADDR_W-1:0]   group_base;
  logic [7:0]          byte_v;
  logic                full;
  logic                last_byte;
  logic [2:0]          low_zero;
  logic [7:0]          bit_mask;
  logic                cur_set;
  logic                cnt_inc;
  logic                cnt_dec;
  logic                res_load;
  logic [STATUS_W-1:0] res_status_next;
  logic                res_in_use_next;
  logic                rsp_load;
  logic [INODE_W-1:0]  done_inode;

  gia_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr_next),
    .rdata (rdata)
  );

  // group choice for allocate
  always_comb begin
    pick_g  = '0;
    pick_ok = 1'b0;
    for (int k = NUM_GROUPS - 1; k >= 0; k--) begin
      if (counts[k] != '0) begin
        pick_g  = GRP_W'(k);
        pick_ok = 1'b1;
      end
    end
    bad_grp  = !grp_r[GROUP_W-1] &&
               ({1'b0, grp_r[GROUP_W-2:0]} >= GROUP_W'(NUM_GROUPS));
    pref_g   = grp_r[GRP_W-1:0];
    alloc_g  = grp_r[GROUP_W-1] ? pick_g : pref_g;
    alloc_ok = grp_r[GROUP_W-1] ? pick_ok : (counts[pref_g] != '0);
  end

  // group of an inode number by compare against the group bases
  always_comb begin
    inum_ext  = CALC_W'(inum_r);
    off       = inum_ext - CALC_W'(1);
    bad_inode = (inum_r == '0) || (inum_ext > CALC_W'(TOTAL_INODES));
    inode_g   = '0;
    for (int k = 1; k < NUM_GROUPS; k++) begin
      if (off >= CALC_W'(k * INODES_PER_GROUP)) begin
        inode_g = GRP_W'(k);
      end
    end
  end

  // byte address and bit of the addressed entry
  always_comb begin
    loc_off    = off_r - CALC_W'(32'(g_r) * INODES_PER_GROUP);
    group_base = ADDR_W'(32'(g_r) * BYTES_PER_GROUP);
    last_byte  = (byte_r == BYTE_W'(BYTES_PER_GROUP - 1));
    byte_v     = rdata | (last_byte ? PAD_MASK : 8'h00);
    full       = (byte_v == FULL_BYTE);
    low_zero   = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (!byte_v[i]) begin
        low_zero = 3'(i);
      end
    end
    bit_mask   = 8'h01 << bit_r;
    cur_set    = rdata[bit_r];
    done_inode = INODE_W'(32'(g_r) * INODES_PER_GROUP + 32'(byte_r) * 8 +
                          32'(bit_r) + 1);
  end

  // sequencer: decode, read, modify and write back
  always_comb begin
    state_next      = state;
    ram_we          = 1'b0;
    ram_waddr       = rd_addr;
    ram_wdata       = rdata;
    rd_addr_next    = rd_addr;
    cnt_inc         = 1'b0;
    cnt_dec         = 1'b0;
    res_load        = 1'b0;
    res_status_next = STS_OK;
    res_in_use_next = 1'b0;
    rsp_load        = 1'b0;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = 8'h00;
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (op_r == OP_ALLOC) begin
          if (bad_grp) begin
            res_load        = 1'b1;
            res_status_next = STS_BAD_GROUP;
            state_next      = S_DONE;
          end else if (!alloc_ok) begin
            res_load        = 1'b1;
            res_status_next = STS_NO_FREE;
            state_next      = S_DONE;
          end else begin
            state_next = S_ADDR;
          end
        end else if (bad_inode) begin
          res_load        = 1'b1;
          res_status_next = STS_BAD_INODE;
          state_next      = S_DONE;
        end else begin
          state_next = S_ADDR;
        end
      end
      S_ADDR: begin
        if (op_r == OP_ALLOC) begin
          rd_addr_next = group_base;
        end else begin
          rd_addr_next = group_base + ADDR_W'(loc_off >> 3);
        end
        state_next = S_RDATA;
      end
      S_RDATA: begin
        if (op_r == OP_ALLOC) begin
          if (full) begin
            if (last_byte) begin
              res_load        = 1'b1;
              res_status_next = STS_NO_FREE;
              state_next      = S_DONE;
            end else begin
              rd_addr_next = rd_addr + ADDR_W'(1);
            end
          end else begin
            ram_we          = 1'b1;
            ram_wdata       = rdata | (8'h01 << low_zero);
            cnt_dec         = 1'b1;
            res_load        = 1'b1;
            res_in_use_next = 1'b1;
            state_next      = S_DONE;
          end
        end else begin
          res_load   = 1'b1;
          state_next = S_DONE;
          if (op_r == OP_FREE && cur_set) begin
            ram_we          = 1'b1;
            ram_wdata       = rdata & ~bit_mask;
            cnt_inc         = 1'b1;
            res_in_use_next = 1'b0;
          end else if (op_r == OP_MARK && !cur_set) begin
            ram_we          = 1'b1;
            ram_wdata       = rdata | bit_mask;
            cnt_dec         = 1'b1;
            res_in_use_next = 1'b1;
          end else begin
            res_in_use_next = cur_set;
          end
        end
      end
      S_DONE: begin
        if (!rsp_valid || rsp.ready) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state, counts and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      total     <= TOT_W'(TOTAL_INODES);
      rsp_valid <= 1'b0;
      for (int k = 0; k < NUM_GROUPS; k++) begin
        counts[k] <= CNT_W'(INODES_PER_GROUP);
      end
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (cnt_dec) begin
        counts[g_r] <= counts[g_r] - CNT_W'(1);
        total       <= total - TOT_W'(1);
      end else if (cnt_inc) begin
        counts[g_r] <= counts[g_r] + CNT_W'(1);
        total       <= total + TOT_W'(1);
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // working and response payload registers
  always_ff @(posedge clk) begin
    rd_addr <= rd_addr_next;
    if (state == S_IDLE && req.valid) begin
      op_r   <= req.operation;
      inum_r <= req.inode_number;
      grp_r  <= req.preferred_group;
    end
    if (state == S_DECODE) begin
      g_r    <= (op_r == OP_ALLOC) ? alloc_g : inode_g;
      off_r  <= off;
      byte_r <= '0;
    end
    if (state == S_ADDR && op_r != OP_ALLOC) begin
      bit_r <= loc_off[2:0];
    end
    if (state == S_RDATA && op_r == OP_ALLOC) begin
      if (full) begin
        byte_r <= byte_r + BYTE_W'(1);
      end else begin
        bit_r <= low_zero;
      end
    end
    if (res_load) begin
      res_status <= res_status_next;
      res_in_use <= res_in_use_next;
    end
    if (rsp_load) begin
      rsp_status <= res_status;
      rsp_in_use <= res_in_use;
      rsp_total  <= INODE_W'(total);
      rsp_inode  <= (op_r == OP_ALLOC && res_status == STS_OK) ? done_inode : '0;
    end
  end

  // channel outputs
  assign req.ready            = (state == S_IDLE);
  assign rsp.valid            = rsp_valid;
  assign rsp.status           = rsp_status;
  assign rsp.allocated_inode  = rsp_inode;
  assign rsp.in_use           = rsp_in_use;
  assign rsp.total_free_count = rsp_total;

  // checks on the counts and the write path
  `ASSERT_NEVER(a_total_range, clk, rst, total > TOT_W'(TOTAL_INODES))
  `ASSERT_NEVER(a_cnt_underflow, clk, rst, cnt_dec && (counts[g_r] == '0 || total == '0))
  `ASSERT_NEVER(a_cnt_overflow, clk, rst, cnt_inc && counts[g_r] == CNT_W'(INODES_PER_GROUP))
  `ASSERT_CLK(a_write_src, clk, rst, ram_we |-> (state == S_CLEAR || state == S_RDATA))
  `ASSERT_CLK(a_rsp_from_done, clk, rst, $rose(rsp_valid) |-> $past(state) == S_DONE)

endmodule

[rtl/gia_ram.sv]
// generic single-write, single-read ram with registered read data
module gia_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sim/grouped_inode_bitmap_allocator_unit_tb.sv]
// self-checking testbench of the grouped inode bitmap allocator with its own bitmap predictor
module grouped_inode_bitmap_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gia_pkg::*;

  // geometry of the instance under test
  localparam int NUM_GROUPS       = DEF_NUM_GROUPS;
  localparam int INODES_PER_GROUP = DEF_INODES_PER_GROUP;
  localparam int BYTES_PER_GROUP  = (INODES_PER_GROUP + 7) / 8;
  localparam int TOTAL_INODES     = NUM_GROUPS * INODES_PER_GROUP;
  localparam int RANDOM_ITEMS     = 950;
  localparam int HOLD_AT_RESULT   = 200;
  localparam int LONG_HOLD        = 100;
  localparam int CYCLE_LIMIT      = 300000;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [INODE_W-1:0]  allocated_inode;
    logic                in_use;
    logic [INODE_W-1:0]  total_free_count;
  } alloc_result_t;

  class inode_alloc_scoreboard;
    logic [7:0]    usage_map [NUM_GROUPS*BYTES_PER_GROUP];
    int unsigned   group_free [NUM_GROUPS];
    int unsigned   free_total;
    alloc_result_t expected_results [$];
    int unsigned   mismatches, checked;
    int unsigned   n_taken, n_no_free, n_bad_inode, n_bad_group, n_flips;

    function new();
      foreach (usage_map[i]) usage_map[i] = '0;
      foreach (group_free[g]) group_free[g] = INODES_PER_GROUP;
      free_total = TOTAL_INODES;
    endfunction

    // first fit over groups lo..hi, returns the 1-based inode or 0
    function int unsigned take_first_free(int lo, int hi);
      int unsigned local_idx;
      for (int g = lo; g <= hi; g++) begin
        if (group_free[g] == 0) continue;
        for (int b = 0; b < BYTES_PER_GROUP; b++) begin
          if (usage_map[g*BYTES_PER_GROUP + b] == FULL_BYTE) continue;
          for (int i = 0; i < 8; i++) begin
            local_idx = b * 8 + i;
            // padding bits of a partial last byte are never handed out
            if (local_idx >= INODES_PER_GROUP) break;
            if (!usage_map[g*BYTES_PER_GROUP + b][i]) begin
              usage_map[g*BYTES_PER_GROUP + b][i] = 1'b1;
              group_free[g]--;
              free_total--;
              return g * INODES_PER_GROUP + local_idx + 1;
            end
          end
        end
      end
      return 0;
    endfunction

    // apply one accepted request to the shadow state and queue its result
    function void note_request(logic [OP_W-1:0] op, logic [INODE_W-1:0] inum,
                               logic signed [GROUP_W-1:0] grp);
      alloc_result_t r;
      int            g_req;
      int unsigned   got, pos, grp_idx, local_idx, byte_idx, bit_idx;
      logic          was_set;
      g_req = grp;
      r.status = STS_OK;
      r.allocated_inode = '0;
      r.in_use = 1'b0;
      if (op == OP_ALLOC) begin
        if (g_req >= NUM_GROUPS) begin
          r.status = STS_BAD_GROUP;
          n_bad_group++;
        end else begin
          // a negative group searches every group, lowest first
          got = (g_req < 0) ? take_first_free(0, NUM_GROUPS - 1) : take_first_free(g_req, g_req);
          if (got != 0) begin
            r.allocated_inode = got[INODE_W-1:0];
            r.in_use = 1'b1;
            n_taken++;
          end else begin
            r.status = STS_NO_FREE;
            n_no_free++;
          end
        end
      end else if (inum == 0 || inum > TOTAL_INODES) begin
        r.status = STS_BAD_INODE;
        n_bad_inode++;
      end else begin
        pos = inum - 1;
        grp_idx = pos / INODES_PER_GROUP;
        local_idx = pos % INODES_PER_GROUP;
        byte_idx = grp_idx * BYTES_PER_GROUP + local_idx / 8;
        bit_idx = local_idx % 8;
        was_set = usage_map[byte_idx][bit_idx];
        // counts move only on a real flip
        if (op == OP_FREE && was_set) begin
          usage_map[byte_idx][bit_idx] = 1'b0;
          group_free[grp_idx]++;
          free_total++;
          was_set = 1'b0;
          n_flips++;
        end else if (op == OP_MARK && !was_set) begin
          usage_map[byte_idx][bit_idx] = 1'b1;
          group_free[grp_idx]--;
          free_total--;
          was_set = 1'b1;
          n_flips++;
        end
        r.in_use = was_set;
      end
      r.total_free_count = free_total[INODE_W-1:0];
      expected_results.push_back(r);
    endfunction

    // compare one result with the oldest expectation
    function void check_result(alloc_result_t got);
      alloc_result_t want;
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d allocated_inode %0d in_use %0d total_free %0d",
               got.status, got.allocated_inode, got.in_use, got.total_free_count);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      checked++;
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.allocated_inode !== want.allocated_inode) begin
        $error("allocated_inode: expected %0d, got %0d", want.allocated_inode,
               got.allocated_inode);
        mismatches++;
      end
      if (got.in_use !== want.in_use) begin
        $error("in_use: expected %0d, got %0d", want.in_use, got.in_use);
        mismatches++;
      end
      if (got.total_free_count !== want.total_free_count) begin
        $error("total_free_count: expected %0d, got %0d", want.total_free_count,
               got.total_free_count);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  bit          no_idle = 1'b0;
  int unsigned sent = 0;
  int unsigned rsp_count = 0;
  int unsigned cycle_count = 0;

  inode_alloc_scoreboard sb = new();

  gia_req_if req ();
  gia_rsp_if rsp ();

  grouped_inode_bitmap_allocator_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // idle cycles before the next item on either side
  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 5);
  endfunction

  // offer one request and wait for its acceptance
  task automatic drive_request(logic [OP_W-1:0] op, int inum, int grp);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.operation <= op;
    req.inode_number <= inum[INODE_W-1:0];
    req.preferred_group <= grp[GROUP_W-1:0];
    do @(posedge clk); while (req.ready !== 1'b1);
    sb.note_request(op, inum[INODE_W-1:0], grp[GROUP_W-1:0]);
    sent++;
  endtask

  // stop offering and wait until every queued result has come back
  task automatic wait_for_results();
    req.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // random request: alloc_pct of allocations, any_pct of those search all groups
  task automatic random_request(int unsigned alloc_pct, int unsigned any_pct);
    logic [OP_W-1:0] op;
    int unsigned     pick, kind;
    int              inum, grp;
    pick = $urandom_range(0, 99);
    grp = int'($urandom_range(0, 31)) - 16;
    inum = $urandom_range(0, 4095);
    if (pick < alloc_pct) begin
      kind = $urandom_range(0, 99);
      if (kind < any_pct) grp = -int'($urandom_range(1, 16));
      else if (kind < 90) grp = $urandom_range(0, NUM_GROUPS - 1);
      else grp = $urandom_range(NUM_GROUPS, 15);
      drive_request(OP_ALLOC, inum, grp);
    end else begin
      // mostly inodes in the low groups where allocations land
      kind = $urandom_range(0, 9);
      if (kind < 6) inum = $urandom_range(1, 2 * INODES_PER_GROUP);
      else if (kind < 9) inum = $urandom_range(1, TOTAL_INODES);
      else inum = $urandom_range(0, 1) ? 0 : $urandom_range(TOTAL_INODES + 1, 4095);
      case ($urandom_range(0, 2))
        0: op = OP_FREE;
        1: op = OP_MARK;
        default: op = OP_QUERY;
      endcase
      drive_request(op, inum, grp);
    end
  endtask

  // result side: random stalls and one long hold-off that backs up the block
  initial begin
    int            stall;
    alloc_result_t got;
    rsp.ready = 1'b0;
    forever begin
      stall = (rsp_count == HOLD_AT_RESULT) ? LONG_HOLD : draw_gap();
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (rsp.valid !== 1'b1);
      got.status = rsp.status;
      got.allocated_inode = rsp.allocated_inode;
      got.in_use = rsp.in_use;
      got.total_free_count = rsp.total_free_count;
      sb.check_result(got);
      rsp_count++;
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $error("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
    $display("FAILED: results differ");
    $finish;
  end

  // stimulus
  initial begin
    int unsigned n, burst_end;
    rst = 1'b1;
    req.valid = 1'b0;
    req.operation = OP_QUERY;
    req.inode_number = '0;
    req.preferred_group = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, every operation, error and no-flip cases
    drive_request(OP_QUERY, 1, 15);
    drive_request(OP_ALLOC, 4095, -1);
    drive_request(OP_ALLOC, 0, 0);
    drive_request(OP_ALLOC, 0, NUM_GROUPS - 1);
    drive_request(OP_ALLOC, 0, 15);
    drive_request(OP_ALLOC, 0, NUM_GROUPS);
    drive_request(OP_ALLOC, 0, -16);
    drive_request(OP_MARK, TOTAL_INODES, 0);
    drive_request(OP_QUERY, TOTAL_INODES, 0);
    drive_request(OP_MARK, TOTAL_INODES, 0);
    drive_request(OP_FREE, TOTAL_INODES, 0);
    drive_request(OP_FREE, TOTAL_INODES, 0);
    drive_request(OP_QUERY, 0, 0);
    drive_request(OP_FREE, 0, -1);
    drive_request(OP_MARK, TOTAL_INODES + 1, 7);
    drive_request(OP_QUERY, 4095, -16);
    drive_request(OP_FREE, 1, 0);
    drive_request(OP_ALLOC, 0, -1);
    drive_request(OP_ALLOC, 0, -1);
    drive_request(OP_MARK, INODES_PER_GROUP, 3);
    drive_request(OP_MARK, INODES_PER_GROUP + 1, 3);
    drive_request(OP_QUERY, 1024, -1);
    drive_request(OP_FREE, (NUM_GROUPS - 1) * INODES_PER_GROUP + 1, 0);
    drive_request(OP_ALLOC, 0, NUM_GROUPS - 1);
    wait_for_results();

    // fill group 0 through searches of all groups, with holes punched on the way
    n = 0;
    while (n < 450 && (n < 320 || sb.group_free[0] != 0)) begin
      random_request(90, 85);
      n++;
    end
    wait_for_results();

    // mixed traffic, the first stretch back to back
    no_idle = 1'b1;
    burst_end = n + 100;
    while (n < RANDOM_ITEMS) begin
      if (n == burst_end) no_idle = 1'b0;
      random_request(40, 40);
      n++;
    end

    wait_for_results();
    repeat (40) @(posedge clk);
    $display("%0d requests: %0d inodes taken, %0d none free, %0d bad inode, %0d bad group",
             sent, sb.n_taken, sb.n_no_free, sb.n_bad_inode, sb.n_bad_group);
    $display("%0d free/mark flips, %0d results checked, %0d mismatches",
             sb.n_flips, sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
